[rtl/sobel_gradient_3x3_core_assert.svh]
// ----------------------------------------------------------------------------
// sobel_gradient_3x3_core_assert.svh
// Assertion macros shared by the Sobel gradient core.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_3X3_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_3X3_CORE_ASSERT_SVH

// same-cycle implication
`define SGC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sgc_pkg.sv]
// ----------------------------------------------------------------------------
// sgc_pkg
// Types and constants of the 3x3 Sobel gradient core.
// ----------------------------------------------------------------------------
package sgc_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W = 16;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LW_W = 13;
  localparam int unsigned SUM_W = PIX_W + 3;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [LW_W-1:0] LW_MIN = LW_W'(3);
  localparam logic [LW_W-1:0] LW_MAX = LW_W'(MAX_WIDTH);
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
  localparam logic [COORD_W-1:0] ROW_SAT = '1;
  localparam logic [COORD_W-1:0] EDGE_MIN = COORD_W'(2);
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);
  localparam logic signed [SUM_W-1:0] GRAD_MAX = SUM_W'(65535);

  localparam logic DIR_HORIZ = 1'b0;
  localparam logic DIR_VERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] px_top;
    logic [PIX_W-1:0] px_mid;
    logic [PIX_W-1:0] px_bot;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic emit;
  } sgc_item_t;

endpackage

[rtl/sgc_ram.sv]
// ----------------------------------------------------------------------------
// sgc_ram
// Simple dual-port RAM, one write and one registered read port, read-old.
// ----------------------------------------------------------------------------
module sgc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sgc_front.sv]
// ----------------------------------------------------------------------------
// sgc_front
// Pixel intake: coordinate tracking, line store access, item classification.
// ----------------------------------------------------------------------------
module sgc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [sgc_pkg::PIX_W-1:0] pixel,
  input  logic                      frame_start,
  input  logic [sgc_pkg::LW_W-1:0]  line_width,
  input  logic [sgc_pkg::QCNT_W-1:0] q_count,
  output logic                      push,
  output sgc_pkg::sgc_item_t        push_item
);
  import sgc_pkg::*;

  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [COORD_W-1:0] col_cur, row_cur;
  logic [LW_W-1:0]    eff_w;
  logic               wrap, accept;
  logic [ADDR_W-1:0]  idx;
  logic [PIX_W-1:0]   pix_in;
  logic [PIX_W-1:0]   a_rd, b_rd;

  logic               f1_valid_r;
  logic [ADDR_W-1:0]  f1_idx_r;
  logic [PIX_W-1:0]   f1_pix_r;
  logic [COORD_W-1:0] f1_col_r, f1_row_r;
  logic               f1_emit_r;
  logic               fwd_r;
  logic [PIX_W-1:0]   mid_prev_r;

  assign in_tready = ({1'b0, q_count} + (QCNT_W + 1)'(f1_valid_r)) < (QCNT_W + 1)'(QDEPTH);
  assign accept = in_tvalid && in_tready;
  assign pix_in = pixel & PIX_MASK;

  always_comb begin
    if (line_width < LW_MIN) begin
      eff_w = LW_MIN;
    end else if (line_width > LW_MAX) begin
      eff_w = LW_MAX;
    end else begin
      eff_w = line_width;
    end
  end

  assign col_cur = frame_start ? '0 : col_r;
  assign row_cur = frame_start ? '0 : row_r;
  assign idx = col_cur[ADDR_W-1:0];
  assign wrap = ({1'b0, col_cur} + LW_W'(1)) >= eff_w;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = (row_cur < ROW_SAT) ? row_cur + COORD_W'(1) : row_cur;
      end else begin
        col_nxt = col_cur + COORD_W'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      f1_valid_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      f1_valid_r <= accept;
      fwd_r <= accept && f1_valid_r && (f1_idx_r == idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_idx_r <= idx;
      f1_pix_r <= pix_in;
      f1_col_r <= col_cur;
      f1_row_r <= row_cur;
      f1_emit_r <= (col_cur >= EDGE_MIN) && (row_cur >= EDGE_MIN);
    end
    if (f1_valid_r) begin
      mid_prev_r <= a_rd;
    end
  end

  sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (accept),
    .waddr (idx),
    .wdata (pix_in),
    .re    (accept),
    .raddr (idx),
    .rdata (a_rd)
  );

  sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (f1_valid_r),
    .waddr (f1_idx_r),
    .wdata (a_rd),
    .re    (accept),
    .raddr (idx),
    .rdata (b_rd)
  );

  assign push = f1_valid_r;

  always_comb begin
    push_item.px_top = fwd_r ? mid_prev_r : b_rd;
    push_item.px_mid = a_rd;
    push_item.px_bot = f1_pix_r;
    push_item.col = f1_col_r - COORD_W'(1);
    push_item.row = f1_row_r - COORD_W'(1);
    push_item.emit = f1_emit_r;
  end

endmodule

[rtl/sgc_fifo.sv]
// ----------------------------------------------------------------------------
// sgc_fifo
// Short queue of classified items between intake and kernel stage.
// ----------------------------------------------------------------------------
module sgc_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  sgc_pkg::sgc_item_t         push_item,
  input  logic                       pop,
  output logic                       head_valid,
  output sgc_pkg::sgc_item_t         head_item,
  output logic [sgc_pkg::QCNT_W-1:0] count
);
  import sgc_pkg::*;

  sgc_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

[rtl/sgc_back.sv]
// ----------------------------------------------------------------------------
// sgc_back
// Window shift, Sobel kernel, clamp and output register.
// ----------------------------------------------------------------------------
module sgc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  sgc_pkg::sgc_item_t               head_item,
  output logic                             pop,
  input  logic                             direction,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sgc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sgc_pkg::*;

  logic [PIX_W-1:0] w1_t_r, w1_m_r, w1_b_r;
  logic [PIX_W-1:0] w2_t_r, w2_m_r, w2_b_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] grad_r, grad_nxt;
  logic [COORD_W-1:0] col_r, row_r;

  logic signed [SUM_W-1:0] c0t, c0m, c0b, c1t, c1b, c2t, c2m, c2b;
  logic signed [SUM_W-1:0] sum;

  assign pop = head_valid && (!out_valid_r || out_tready);

  assign c0t = $signed(SUM_W'(w1_t_r));
  assign c0m = $signed(SUM_W'(w1_m_r));
  assign c0b = $signed(SUM_W'(w1_b_r));
  assign c1t = $signed(SUM_W'(w2_t_r));
  assign c1b = $signed(SUM_W'(w2_b_r));
  assign c2t = $signed(SUM_W'(head_item.px_top));
  assign c2m = $signed(SUM_W'(head_item.px_mid));
  assign c2b = $signed(SUM_W'(head_item.px_bot));

  always_comb begin
    if (direction == DIR_VERT) begin
      sum = (c0b - c0t) + ((c1b - c1t) <<< 1) + (c2b - c2t);
    end else begin
      sum = (c2t - c0t) + ((c2m - c0m) <<< 1) + (c2b - c0b);
    end
    if (sum < 0) begin
      grad_nxt = '0;
    end else if (sum > GRAD_MAX) begin
      grad_nxt = GRAD_MAX[PIX_W-1:0];
    end else begin
      grad_nxt = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      w1_t_r <= '0;
      w1_m_r <= '0;
      w1_b_r <= '0;
      w2_t_r <= '0;
      w2_m_r <= '0;
      w2_b_r <= '0;
    end else if (pop) begin
      out_valid_r <= head_item.emit;
      w1_t_r <= w2_t_r;
      w1_m_r <= w2_m_r;
      w1_b_r <= w2_b_r;
      w2_t_r <= head_item.px_top;
      w2_m_r <= head_item.px_mid;
      w2_b_r <= head_item.px_bot;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.emit) begin
      grad_r <= grad_nxt;
      col_r <= head_item.col;
      row_r <= head_item.row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {row_r, col_r, grad_r};

endmodule

[rtl/sobel_gradient_3x3_core.sv]
// Path: an accepted pixel passes the line store read stage, the item queue and the output register to out_tvalid.
// Throughput: one pixel per cycle; intake stalls only when the items in the 4-entry
//   item queue plus the one in the line store read stage reach the queue depth.
// Reset: synchronous active-low; clears coordinates, window and config
//   (direction 0, line_width 640). Line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_gradient_3x3_core
// 3x3 Sobel gradient on a raster pixel stream with two line stores.
// ----------------------------------------------------------------------------
`include "sobel_gradient_3x3_core_assert.svh"

module sobel_gradient_3x3_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sgc_pkg::IN_TDATA_W-1:0]      in_tdata,  // [15:0] pixel
  input  logic                                in_tuser,  // [0] frame_start
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sgc_pkg::OUT_TDATA_W-1:0]     out_tdata, // [15:0] gradient,
                                                         // [27:16] out_col,
                                                         // [39:28] out_row
  input  logic                                cfg_we,
  input  logic [sgc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [sgc_pkg::LW_W-1:0]            cfg_wdata
);
  import sgc_pkg::*;

  logic              direction_r;
  logic [LW_W-1:0]   line_width_r;
  logic              push, pop, head_valid;
  sgc_item_t         push_item, head_item;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_HORIZ;
      line_width_r <= LW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DIRECTION:  direction_r <= cfg_wdata[0];
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sgc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .pixel       (in_tdata[PIX_W-1:0]),
    .frame_start (in_tuser),
    .line_width  (line_width_r),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  sgc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  sgc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .direction  (direction_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `SGC_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_count <= QCNT_W'(QDEPTH), "queue overflow")
  `SGC_ASSERT_IMP(a_out_interior, clk, rst_n, out_tvalid, (out_tdata[27:16] != '0) && (out_tdata[39:28] != '0), "border pixel emitted")
  `SGC_ASSERT_IMP(a_accept_queued, clk, rst_n, in_tvalid && in_tready, ##2 (q_count != '0), "accepted beat not queued")
  `SGC_ASSERT_NXT(a_stall_full, clk, rst_n, !in_tready, (q_count != '0), "intake stalled with empty queue")

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 Sobel gradient core. A directed table drives
// one three-pixel-wide frame through both kernels and both clamp limits.
// Random frames follow, with narrow and clamped widths, mid-row width cuts and
// stray frame starts. Each result beat is checked field by field against an
// in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgc_pkg::*;

  localparam int RANDOM_PIXELS = 1200;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int SCRIPT_LEN = 26;

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } grad_beat_t;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [LW_W-1:0] reg_val;
    logic [PIX_W-1:0] pix;
    bit fs;
    bit typed;
    grad_beat_t beat;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [15:0] pixel
  logic in_tuser = 1'b0;                  // [0] frame_start
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [15:0] gradient, [27:16] out_col,
                                          // [39:28] out_row
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [LW_W-1:0] cfg_wdata = '0;

  bit [PIX_W-1:0] row_above [MAX_WIDTH];
  bit [PIX_W-1:0] row_two_above [MAX_WIDTH];
  bit [PIX_W-1:0] nbhd [9];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic kernel_dir = DIR_HORIZ;
  logic [LW_W-1:0] width_reg = LW_RESET;

  grad_beat_t gradient_q [$];
  script_row_t script [SCRIPT_LEN];
  bit burst_mode = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int gradients_seen = 0;
  int regs_written = 0;

  sobel_gradient_3x3_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int active_width(logic [LW_W-1:0] v);
    if (v < LW_MIN) return int'(LW_MIN);
    if (v > LW_MAX) return int'(LW_MAX);
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic script_row_t pix_row(logic [PIX_W-1:0] pix, bit fs);
    script_row_t s;
    s = '{STEP_PIXEL, '0, '0, pix, fs, 1'b0, '0};
    return s;
  endfunction

  function automatic script_row_t pix_check(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] grad,
                                            int col, int row);
    script_row_t s;
    s = '{STEP_PIXEL, '0, '0, pix, 1'b0, 1'b1, '0};
    s.beat = '{gradient: grad, col: COORD_W'(col), row: COORD_W'(row)};
    return s;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [LW_W-1:0] val);
    script_row_t s;
    s = '{STEP_REG, idx, val, '0, 1'b0, 1'b0, '0};
    return s;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, gradients_seen, got, want);
  endtask

  task automatic predict_gradient(input logic [PIX_W-1:0] pix, input bit fs,
                                  output bit emit, output grad_beat_t beat);
    int unsigned w;
    int unsigned idx;
    int p [9];
    int sum;
    bit [PIX_W-1:0] top;
    bit [PIX_W-1:0] mid;
    w = active_width(width_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    idx = col_pos % MAX_WIDTH;
    top = row_two_above[idx];
    mid = row_above[idx];
    row_two_above[idx] = mid;
    row_above[idx] = pix;
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3] = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = pix;
    emit = (col_pos >= 2) && (row_pos >= 2);
    beat = '0;
    if (emit) begin
      foreach (p[i]) p[i] = nbhd[i];
      if (kernel_dir == DIR_HORIZ)
        sum = (p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]);
      else
        sum = (p[6] - p[0]) + 2 * (p[7] - p[1]) + (p[8] - p[2]);
      if (sum < 0) sum = 0;
      else if (sum > 65535) sum = 65535;
      beat.gradient = PIX_W'(sum);
      beat.col = COORD_W'(col_pos - 1);
      beat.row = COORD_W'(row_pos - 1);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < ROW_SAT) row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit fs, input bit typed,
                            input grad_beat_t typed_beat);
    int gap;
    bit emit;
    grad_beat_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    predict_gradient(pix, fs, emit, beat);
    if (emit) gradient_q.push_back(typed ? typed_beat : beat);
    pixels_sent++;
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LW_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DIRECTION) kernel_dir = val[0];
    else width_reg = val;
    regs_written++;
  endtask

  // shrink the width mid-frame at a random cut; never grow it inside a frame
  task automatic run_frame(input logic [LW_W-1:0] width_val, input int rows,
                           input bit allow_cut);
    int eff;
    int npix;
    int cut;
    settle_pipeline();
    burst_mode = ($urandom_range(0, 4) == 0);
    write_reg(CFG_DIRECTION, LW_W'($urandom_range(0, 1)));
    write_reg(CFG_LINE_WIDTH, width_val);
    eff = active_width(width_val);
    npix = eff * rows + $urandom_range(0, eff - 1);
    cut = npix;
    if (allow_cut && $urandom_range(0, 3) == 0) cut = $urandom_range(1, npix - 1);
    for (int i = 0; i < npix; i++) begin
      if (i == cut) begin
        settle_pipeline();
        write_reg(CFG_LINE_WIDTH, LW_W'($urandom_range(0, eff)));
      end
      push_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 199) == 0), 1'b0, '0);
    end
  endtask

  initial begin : result_side
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    grad_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      gradients_seen++;
      if (gradient_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 0);
      end else begin
        want = gradient_q.pop_front();
        if (out_tdata[PIX_W-1:0] !== want.gradient)
          report_mismatch("gradient", out_tdata[PIX_W-1:0], want.gradient);
        if (out_tdata[PIX_W +: COORD_W] !== want.col)
          report_mismatch("out_col", out_tdata[PIX_W +: COORD_W], want.col);
        if (out_tdata[PIX_W+COORD_W +: COORD_W] !== want.row)
          report_mismatch("out_row", out_tdata[PIX_W+COORD_W +: COORD_W], want.row);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int directed_pixels;
    // width 0 behaves as 3; direction left at its reset value (horizontal)
    script = '{
      reg_row(CFG_LINE_WIDTH, '0),
      pix_row(16'h0000, 1'b1), pix_row(16'h0000, 1'b0), pix_row(16'hFFFF, 1'b0),
      pix_row(16'h0000, 1'b0), pix_row(16'h0000, 1'b0), pix_row(16'hFFFF, 1'b0),
      pix_row(16'h0000, 1'b0), pix_row(16'h0000, 1'b0), pix_check(16'hFFFF, 16'hFFFF, 1, 1),
      pix_row(16'hFFFF, 1'b0), pix_row(16'h0000, 1'b0), pix_row(16'h0000, 1'b0),
      pix_row(16'hFFFF, 1'b0), pix_row(16'h0000, 1'b0), pix_row(16'h0000, 1'b0),
      pix_row(16'hFFFF, 1'b0), pix_row(16'h0000, 1'b0), pix_check(16'h0000, 16'h0000, 1, 4),
      reg_row(CFG_DIRECTION, LW_W'(DIR_VERT)),
      pix_row(16'hFFFF, 1'b0), pix_row(16'hFFFF, 1'b0), pix_check(16'hFFFF, 16'hFFFF, 1, 5),
      pix_row(16'h0000, 1'b0), pix_row(16'h0000, 1'b0), pix_check(16'h0000, 16'h0000, 1, 6)
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        settle_pipeline();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        push_pixel(script[i].pix, script[i].fs, script[i].typed, script[i].beat);
      end
    end
    directed_pixels = pixels_sent;

    while (pixels_sent < directed_pixels + RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0: run_frame(LW_W'($urandom_range(0, 2)), $urandom_range(3, 6), 1'b1);
        1: run_frame(LW_W'($urandom_range(41, 200)), 3, 1'b1);
        default: run_frame(LW_W'($urandom_range(3, 12)), $urandom_range(3, 6), 1'b1);
      endcase
    end
    settle_pipeline();

    $display("run: %0d pixels in, %0d gradients compared, %0d register writes",
             pixels_sent, gradients_seen, regs_written);
    $display("run: both kernels, both clamp limits, low width clamp, mid-row cuts, restarts");
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
